@@ sv/ttp_pkg.sv @@
package ttp_pkg;

	localparam int CNT_W  = 16;
	localparam int NUM_W  = 32;
	localparam int REM_W  = CNT_W + 1;
	localparam int STEP_W = 6;
	localparam int SH_W   = 4;
	localparam int ADJ_W  = CNT_W + 10;

	localparam logic [0:0] REG_NUMERATOR = 1'b0;
	localparam logic [0:0] REG_TICKS     = 1'b1;

	localparam logic [NUM_W-1:0] NUMERATOR_RST = 32'd1440000000;
	localparam logic [7:0]       TICKS_RST     = 8'd24;

	typedef struct packed {
		logic [15:0] bpm;
		logic        timer_running;
		logic [3:0]  current_select;
		logic [15:0] current_count;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  prescale_select;
		logic [15:0] beat_compare;
		logic [15:0] tick_compare;
		logic [15:0] count_value;
		logic        count_load;
	} rsp_t;

	typedef struct packed {
		logic              go;
		logic [NUM_W-1:0]  dividend;
		logic [CNT_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
		logic [CNT_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CYC,
		S_SEL,
		S_TICK_GO,
		S_TICK,
		S_ADJ,
		S_MOD,
		S_OUT
	} state_t;

	function automatic logic [SH_W-1:0] code_shift(input logic [2:0] code);
		logic [SH_W-1:0] s;
		case (code)
			3'd1:    s = 4'd0;
			3'd2:    s = 4'd1;
			3'd3:    s = 4'd2;
			3'd4:    s = 4'd3;
			3'd5:    s = 4'd6;
			3'd6:    s = 4'd8;
			3'd7:    s = 4'd10;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

@@ sv/ttp_cell.sv @@
module ttp_cell (
	input  logic clk,
	input  logic clr,
	input  logic en,
	input  logic t,
	input  logic d,
	input  logic bin,
	input  logic ge,
	output logic r,
	output logic bout
);
	logic r_q;
	logic diff;

	assign diff = t ^ d ^ bin;
	assign bout = (~t & d) | (~t & bin) | (d & bin);
	assign r    = r_q;

	always_ff @(posedge clk) begin
		if (clr) begin
			r_q <= 1'b0;
		end else if (en) begin
			r_q <= ge ? diff : t;
		end
	end
endmodule

@@ sv/ttp_div.sv @@
module ttp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ttp_pkg::div_req_t  req,
	output ttp_pkg::div_rsp_t  rsp
);
	import ttp_pkg::*;

	logic [NUM_W-1:0]  q_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic              step;
	logic              ge;
	logic [REM_W-1:0]  r;
	logic [REM_W-1:0]  t;
	logic [REM_W-1:0]  d;
	logic [REM_W:0]    b;

	assign step = (cnt_q != '0);
	assign b[0] = 1'b0;
	assign ge   = ~b[REM_W];
	assign t    = {r[REM_W-2:0], q_q[NUM_W-1]};
	assign d    = {1'b0, req.divisor};

	for (genvar k = 0; k < REM_W; k++) begin : g_cell
		ttp_cell u_cell (
			.clk  (clk),
			.clr  (req.go),
			.en   (step),
			.t    (t[k]),
			.d    (d[k]),
			.bin  (b[k]),
			.ge   (ge),
			.r    (r[k]),
			.bout (b[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= step && (cnt_q == STEP_W'(1));
			if (req.go) begin
				cnt_q <= req.steps;
			end else if (step) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			q_q <= req.dividend << (STEP_W'(NUM_W) - req.steps);
		end else if (step) begin
			q_q <= {q_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;
	assign rsp.rem  = r[CNT_W-1:0];
endmodule

@@ sv/tempo_to_timer_prescale_top.sv @@
// tempo to timer prescale
// start with busy low takes one command beat: tempo, timer running flag,
// current prescaler select and current count. busy stays high until the
// result beat, which sits on rsp for exactly one cycle with done high.
// the receiver cannot stall, so the beat must be taken in that cycle.
// a zero tempo goes straight to the result beat; when no prescaler fits,
// the result follows the first division, otherwise the second, or the
// third when the count has to be reduced into range. one command is worked
// on at a time; the next one can be taken once busy is low again.
// the work is done by the bit-serial divider, a row of seventeen remainder
// cells that retires one quotient bit per cycle and runs up to three times
// in turn: numerator by tempo (32 steps), compare by ticks per beat
// (16 steps) and the count remainder (26 steps).
// wr_en writes cycles_numerator (index 0) or ticks_per_beat (index 1)
// at once; write only while busy is low.
// reset returns the registers to 1440000000 and 24 and the control to idle.
module tempo_to_timer_prescale_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ttp_pkg::cmd_t cmd,
	output logic          done,
	output ttp_pkg::rsp_t rsp,
	input  logic          wr_en,
	input  logic [0:0]    wr_idx,
	input  logic [31:0]   wr_data
);
	import ttp_pkg::*;

	state_t            state_q, state_d;
	logic [NUM_W-1:0]  num_q;
	logic [7:0]        tpb_q;
	cmd_t              cmd_q;
	logic [NUM_W-1:0]  cyc_q;
	logic              ok_q;
	logic [2:0]        sel_q;
	logic [CNT_W-1:0]  cmp_q;
	logic [CNT_W-1:0]  tick_q;
	logic [CNT_W-1:0]  adj_q;
	logic              load_q;
	div_req_t          req;
	div_rsp_t          drsp;
	logic              found;
	logic [2:0]        sel_c;
	logic [CNT_W-1:0]  cmp_c;
	logic [ADJ_W-1:0]  adj_c;
	logic              load_c;

	ttp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (drsp)
	);

	always_comb begin
		found = 1'b0;
		sel_c = 3'd7;
		for (int c = 7; c >= 1; c--) begin
			if ((cyc_q >> code_shift(3'(c))) <= NUM_W'(16'hFFFF)) begin
				found = 1'b1;
				sel_c = 3'(c);
			end
		end
		cmp_c = CNT_W'(cyc_q >> code_shift(sel_c));
	end

	assign load_c = cmd_q.timer_running && (cmd_q.current_select != 4'd0)
		&& (cmd_q.current_select[3] == 1'b0)
		&& (cmd_q.current_select[2:0] != sel_q);
	assign adj_c = (ADJ_W'(cmd_q.current_count) << code_shift(sel_q))
		>> code_shift(cmd_q.current_select[2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			num_q   <= NUMERATOR_RST;
			tpb_q   <= TICKS_RST;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (wr_idx)
					REG_NUMERATOR: num_q <= wr_data;
					REG_TICKS:     tpb_q <= wr_data[7:0];
					default:       ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= cmd;
				ok_q   <= 1'b0;
				load_q <= 1'b0;
			end
			S_CYC: begin
				if (drsp.done) begin
					cyc_q <= drsp.quo;
				end
			end
			S_SEL: begin
				ok_q  <= found;
				sel_q <= sel_c;
				cmp_q <= cmp_c;
			end
			S_TICK: begin
				if (drsp.done) begin
					tick_q <= drsp.quo[CNT_W-1:0];
				end
			end
			S_ADJ: begin
				load_q <= load_c;
				if (adj_c > ADJ_W'(cmp_q)) begin
					adj_q <= '0;
				end else begin
					adj_q <= adj_c[CNT_W-1:0];
				end
			end
			S_MOD: begin
				if (drsp.done) begin
					adj_q <= drsp.rem + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		req.go       = 1'b0;
		req.dividend = num_q;
		req.divisor  = cmd_q.bpm;
		req.steps    = STEP_W'(NUM_W);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd.bpm == '0) begin
						state_d = S_OUT;
					end else begin
						req.go  = 1'b1;
						state_d = S_CYC;
					end
				end
			end
			S_CYC: begin
				if (drsp.done) begin
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				state_d = found ? S_TICK_GO : S_OUT;
			end
			S_TICK_GO: begin
				req.go       = 1'b1;
				req.dividend = NUM_W'(cmp_q);
				req.divisor  = (tpb_q == 8'd0) ? CNT_W'(1) : CNT_W'(tpb_q);
				req.steps    = STEP_W'(CNT_W);
				state_d      = S_TICK;
			end
			S_TICK: begin
				req.divisor = (tpb_q == 8'd0) ? CNT_W'(1) : CNT_W'(tpb_q);
				if (drsp.done) begin
					state_d = S_ADJ;
				end
			end
			S_ADJ: begin
				req.dividend = NUM_W'(adj_c - ADJ_W'(1));
				req.divisor  = cmp_q;
				req.steps    = STEP_W'(ADJ_W);
				if (load_c && (adj_c > ADJ_W'(cmp_q)) && (cmp_q != '0)) begin
					req.go  = 1'b1;
					state_d = S_MOD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_MOD: begin
				req.divisor = cmp_q;
				if (drsp.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

	always_comb begin
		rsp.ok              = ok_q;
		rsp.prescale_select = ok_q ? sel_q : 3'd0;
		rsp.beat_compare    = ok_q ? cmp_q : '0;
		rsp.tick_compare    = ok_q ? tick_q : '0;
		rsp.count_load      = ok_q && load_q;
		rsp.count_value     = (ok_q && load_q) ? adj_q : '0;
	end
endmodule
